>>> rtl/tls_record_deframer_top_macros.svh
// ---------------------------------------------------------------------------
// tls record deframer assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef TLS_RECORD_DEFRAMER_TOP_MACROS_SVH
`define TLS_RECORD_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TLSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlsd check failed: same-cycle implication");
// next-cycle implication
`define TLSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlsd check failed: next-cycle implication");
`else
`define TLSD_ASSERT_SAME(label, ante, cons)
`define TLSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/tlsd_pkg.sv
// ---------------------------------------------------------------------------
// tlsd_pkg
// shared types and constants of the tls record deframer
// ---------------------------------------------------------------------------
`default_nettype none

package tlsd_pkg;

    // sticky error codes
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_TYPE    = 2'd1,
        ERR_VERSION = 2'd2,
        ERR_LENGTH  = 2'd3
    } t_err;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_FRAG  = 2'd0;
    localparam logic [1:0] REG_REQ_MAJOR = 2'd1;
    localparam logic [1:0] REG_MIN_MINOR = 2'd2;
    localparam logic [1:0] REG_MAX_MINOR = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;

    // reset values
    localparam int unsigned PLAINTEXT_LIMIT = 16384;
    localparam int unsigned EXPANSION_ALLOW = 2048;
    localparam logic [15:0] MAX_FRAG_RESET  = 16'(PLAINTEXT_LIMIT + EXPANSION_ALLOW);
    localparam logic [7:0]  REQ_MAJOR_RESET = 8'd3;
    localparam logic [7:0]  MIN_MINOR_RESET = 8'd1;
    localparam logic [7:0]  MAX_MINOR_RESET = 8'd3;

    // accepted content types
    localparam logic [7:0] TYPE_MIN = 8'd20;
    localparam logic [7:0] TYPE_MAX = 8'd23;

    typedef struct packed {
        logic [15:0] max_frag;
        logic [7:0]  req_major;
        logic [7:0]  min_minor;
        logic [7:0]  max_minor;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        in_header;
        logic        header_done;
        logic [7:0]  content_type;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [15:0] fragment_length;
        logic        record_end;
        t_err        error_code;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/tlsd_core.sv
// ---------------------------------------------------------------------------
// tlsd_core
// header walk, field checks and fragment byte counter, one byte per cycle while i_accept is high
// ---------------------------------------------------------------------------
`default_nettype none
`include "tls_record_deframer_top_macros.svh"

module tlsd_core
    import tlsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_MAJOR = 3'd1,
        PH_MINOR = 3'd2,
        PH_LEN_H = 3'd3,
        PH_LEN_L = 3'd4,
        PH_FRAG  = 3'd5
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_type,   n_type;
    logic [7:0]  r_major,  n_major;
    logic [7:0]  r_minor,  n_minor;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_left,   n_left;
    t_err        r_err,    n_err;

    logic        hdr, done, rend;
    logic [15:0] len_full;

    assign len_full = {r_len_hi, i_byte};

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_major  = r_major;
        n_minor  = r_minor;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_left   = r_left;
        n_err    = r_err;
        hdr      = 1'b0;
        done     = 1'b0;
        rend     = 1'b0;
        if (r_err == ERR_NONE) begin
            unique case (r_phase)
                PH_FRAG: begin
                    if (r_left <= 16'd1) begin
                        n_left  = '0;
                        rend    = 1'b1;
                        n_phase = PH_TYPE;
                    end else begin
                        n_left = r_left - 16'd1;
                    end
                end
                PH_MAJOR: begin
                    hdr     = 1'b1;
                    n_major = i_byte;
                    if (i_byte != i_cfg.req_major) begin
                        n_err = ERR_VERSION;
                    end else begin
                        n_phase = PH_MINOR;
                    end
                end
                PH_MINOR: begin
                    hdr     = 1'b1;
                    n_minor = i_byte;
                    if (i_byte < i_cfg.min_minor || i_byte > i_cfg.max_minor) begin
                        n_err = ERR_VERSION;
                    end else begin
                        n_phase = PH_LEN_H;
                    end
                end
                PH_LEN_H: begin
                    hdr      = 1'b1;
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_L;
                end
                PH_LEN_L: begin
                    hdr   = 1'b1;
                    n_len = len_full;
                    if (len_full > i_cfg.max_frag) begin
                        n_err = ERR_LENGTH;
                    end else begin
                        done = 1'b1;
                        if (len_full == 16'd0) begin
                            rend    = 1'b1;
                            n_phase = PH_TYPE;
                        end else begin
                            n_left  = len_full;
                            n_phase = PH_FRAG;
                        end
                    end
                end
                default: begin
                    // content type byte, unused codes restart here too
                    hdr     = 1'b1;
                    n_type  = i_byte;
                    n_major = '0;
                    n_minor = '0;
                    n_len   = '0;
                    if (i_byte < TYPE_MIN || i_byte > TYPE_MAX) begin
                        n_err   = ERR_TYPE;
                        n_phase = PH_TYPE;
                    end else begin
                        n_phase = PH_MAJOR;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_result.byte_out        = i_byte;
        o_result.in_header       = hdr;
        o_result.header_done     = done;
        o_result.content_type    = n_type;
        o_result.version_major   = n_major;
        o_result.version_minor   = n_minor;
        o_result.fragment_length = n_len;
        o_result.record_end      = rend;
        o_result.error_code      = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_type   <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_len_hi <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_err    <= ERR_NONE;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_len_hi <= n_len_hi;
            r_len    <= n_len;
            r_left   <= n_left;
            r_err    <= n_err;
        end
    end

    // an error never clears or changes until reset
    `TLSD_ASSERT_NEXT(a_err_sticky, r_err != ERR_NONE, r_err == $past(r_err))
    // parsing is frozen after an error
    `TLSD_ASSERT_NEXT(a_phase_frozen, r_err != ERR_NONE, $stable(r_phase) && $stable(r_left))
    // fragment phase is only entered with bytes still to come
    `TLSD_ASSERT_SAME(a_frag_nonzero, r_phase == PH_FRAG, r_left != 16'd0)

endmodule

`default_nettype wire

>>> rtl/tls_record_deframer_top.sv
// ---------------------------------------------------------------------------
// tls_record_deframer_top
// tls record header checker and framer for a byte stream
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ----------------------------------
//  in       sink       i_valid / o_stall      i_data_byte
//  out      source     o_valid / i_stall      o_byte_out .. o_error_code
//  cfg      sink       i_cfg_we               i_cfg_index, i_cfg_data
//
//  one byte per cycle while i_stall is low, result the cycle after it is taken
//  the whole step is a field compare plus a 16-bit fragment count decrement,
//  done combinationally between the parser state and the result register
//  synchronous active-low reset, bytes are accepted straight out of reset
//  o_stall only rises while a result is held and the sink stalls
//  errors are sticky until reset; register writes do not clear them
//
`default_nettype none
`include "tls_record_deframer_top_macros.svh"

module tls_record_deframer_top
    import tlsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte stream
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    // result stream
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_byte_out,
    output logic             o_in_header,
    output logic             o_header_done,
    output logic [7:0]       o_content_type,
    output logic [7:0]       o_version_major,
    output logic [7:0]       o_version_minor,
    output logic [15:0]      o_fragment_length,
    output logic             o_record_end,
    output logic [1:0]       o_error_code,
    // register writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_cfg    r_cfg;

    // result register and its valid flag
    t_result r_out;
    logic    r_out_valid, n_out_valid;
    t_result core_result;
    logic    in_accept;

    // the result register drains and refills in the same cycle,
    // so the source is held back only when the sink holds us
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frag  <= MAX_FRAG_RESET;
            r_cfg.req_major <= REQ_MAJOR_RESET;
            r_cfg.min_minor <= MIN_MINOR_RESET;
            r_cfg.max_minor <= MAX_MINOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_FRAG:  r_cfg.max_frag  <= i_cfg_data;
                REG_REQ_MAJOR: r_cfg.req_major <= i_cfg_data[7:0];
                REG_MIN_MINOR: r_cfg.min_minor <= i_cfg_data[7:0];
                REG_MAX_MINOR: r_cfg.max_minor <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // header walk and fragment counter
    tlsd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_data_byte),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_byte_out        = r_out.byte_out;
    assign o_in_header       = r_out.in_header;
    assign o_header_done     = r_out.header_done;
    assign o_content_type    = r_out.content_type;
    assign o_version_major   = r_out.version_major;
    assign o_version_minor   = r_out.version_minor;
    assign o_fragment_length = r_out.fragment_length;
    assign o_record_end      = r_out.record_end;
    assign o_error_code      = r_out.error_code;

    // back-pressure only while a result is waiting
    `TLSD_ASSERT_SAME(a_stall_needs_result, o_stall, r_out_valid)
    // a finished header is always a header byte
    `TLSD_ASSERT_SAME(a_done_in_header, r_out_valid && r_out.header_done, r_out.in_header)
    // records only end while no error is latched
    `TLSD_ASSERT_SAME(a_end_no_error, r_out_valid && r_out.record_end,
                      r_out.error_code == ERR_NONE)

endmodule

`default_nettype wire
